/* rtl/core/cosine_similarity_unit_core_macros.svh */
// assertion macros for the cosine similarity core
`ifndef COSINE_SIMILARITY_UNIT_CORE_MACROS_SVH
`define COSINE_SIMILARITY_UNIT_CORE_MACROS_SVH
`ifndef SYNTH
`define CSU_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CSU_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CSU_ASSERT_IMPL(label, clk, rst_n, a, c)
`define CSU_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/core/csu_pkg.sv */
// ----------------------------------------------------------------------------
// csu_pkg
// types and constants shared by the cosine similarity core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package csu_pkg;
    localparam int unsigned MaxVecLenDefault = 1024;
    localparam int unsigned AccW = 48;

    typedef struct packed {
        logic signed [15:0] elem_a;
        logic signed [15:0] elem_b;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [15:0] similarity;
        logic               zero_magnitude;
        logic               saturated;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic [1:0] mul_sel;
        logic       mul_en;
        logic       acc_en;
        logic       sqrt_start;
        logic       sqrt_step;
        logic       mag_mul;
        logic       div_start;
        logic       div_step;
        logic       finish;
    } t_cmd;

    localparam logic [1:0] MulDot = 2'd0;
    localparam logic [1:0] MulA   = 2'd1;
    localparam logic [1:0] MulB   = 2'd2;
endpackage

/* rtl/core/cosine_similarity_unit_core.sv */
// ----------------------------------------------------------------------------
// cosine_similarity_unit_core
// streaming fixed-point cosine similarity of two Q1.15 vectors
// ----------------------------------------------------------------------------
// input channel: one beat per element pair, last marks the final pair
// output channel: one beat per vector, carrying similarity and flags
// each pair runs three products on one shared 16x16 multiplier
// plus load and final accumulate
// a last pair adds a root load and 24 root steps, one magnitude product,
// and a divide load plus 64 restoring steps before the result is valid
// the block takes one item at a time; input ready is low while busy
// when the receiver stalls the result holds and no input is taken
// reset clears sums, clamp flag and the sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cosine_similarity_unit_core_macros.svh"
module cosine_similarity_unit_core import csu_pkg::*; #(
    parameter int unsigned MAX_VEC_LEN = MaxVecLenDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);
    t_cmd cmd;

    csu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_last(i_in_data.last), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_cmd(cmd)
    );

    csu_datapath #(.MAX_VEC_LEN(MAX_VEC_LEN)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in_data),
        .i_cmd(cmd), .o_result(o_out_data)
    );

    // checks
    `CSU_ASSERT_IMPL(a_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `CSU_ASSERT_NEXT(a_take, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `CSU_ASSERT_IMPL(a_zero, i_clk, i_rst_n, o_out_valid && o_out_data.zero_magnitude,
        o_out_data.similarity == 16'sd0)
endmodule

/* rtl/core/csu_datapath.sv */
// ----------------------------------------------------------------------------
// csu_datapath
// shared multiplier, saturating sums, bit-serial roots and restoring divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module csu_datapath import csu_pkg::*; #(
    parameter int unsigned MAX_VEC_LEN = MaxVecLenDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_item,
    input  t_cmd i_cmd,
    output t_out o_result
);
    localparam logic [AccW:0] Bound = (AccW+1)'(MAX_VEC_LEN) << 30;

    logic signed [15:0] r_a, r_b;
    logic signed [31:0] r_prod;
    logic [1:0]         r_psel;
    logic signed [AccW-1:0] r_dot, r_sa, r_sb;
    logic r_clamp;

    // operand latch and shared multiplier
    logic signed [15:0] m_x, m_y;
    always_comb begin
        m_x = r_a; m_y = r_b;
        case (i_cmd.mul_sel)
            MulA:    m_y = r_a;
            MulB:    m_x = r_b;
            default: ;
        endcase
    end

    // saturating accumulate
    logic signed [AccW:0] s_sum, s_clip;
    logic s_over;
    always_comb begin
        case (r_psel)
            MulA:    s_sum = {r_sa[AccW-1], r_sa} + (AccW+1)'(r_prod);
            MulB:    s_sum = {r_sb[AccW-1], r_sb} + (AccW+1)'(r_prod);
            default: s_sum = {r_dot[AccW-1], r_dot} + (AccW+1)'(r_prod);
        endcase
        s_over = 1'b0;
        s_clip = s_sum;
        if (s_sum > $signed(Bound)) begin
            s_clip = $signed(Bound); s_over = 1'b1;
        end else if (s_sum < -$signed(Bound)) begin
            s_clip = -$signed(Bound); s_over = 1'b1;
        end
    end

    // root registers: one result bit per step for both sums
    // the partial remainder never exceeds twice the partial root, so 24 bits hold it
    logic [23:0]     r_rema, r_remb;
    logic [23:0]     r_roota, r_rootb;
    logic [AccW-1:0] r_sqa, r_sqb;
    logic [25:0] cand_a, cand_b, rem_a, rem_b;
    always_comb begin
        rem_a = {r_rema, r_sqa[AccW-1-:2]};
        rem_b = {r_remb, r_sqb[AccW-1-:2]};
        cand_a = {r_roota, 2'b01};
        cand_b = {r_rootb, 2'b01};
    end

    // divider
    logic [47:0] r_den;
    logic [63:0] r_num;
    logic [47:0] r_drem;
    logic [15:0] r_q;
    logic        r_qover;
    logic        r_neg;
    logic [48:0] d_sh;
    assign d_sh = {r_drem, r_num[63]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_item.elem_a; r_b <= i_item.elem_b;
        end
        if (i_cmd.mul_en) begin
            r_prod <= m_x * m_y; r_psel <= i_cmd.mul_sel;
        end
        // running sums and clamp flag
        if (!i_rst_n) begin
            r_dot <= '0; r_sa <= '0; r_sb <= '0; r_clamp <= 1'b0;
        end else if (i_cmd.finish) begin
            r_dot <= '0; r_sa <= '0; r_sb <= '0; r_clamp <= 1'b0;
        end else if (i_cmd.acc_en) begin
            case (r_psel)
                MulA:    r_sa  <= s_clip[AccW-1:0];
                MulB:    r_sb  <= s_clip[AccW-1:0];
                default: r_dot <= s_clip[AccW-1:0];
            endcase
            if (s_over) r_clamp <= 1'b1;
        end
        if (i_cmd.sqrt_start) begin
            r_sqa <= r_sa; r_sqb <= r_sb;
            r_rema <= '0; r_remb <= '0; r_roota <= '0; r_rootb <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sqa <= r_sqa << 2; r_sqb <= r_sqb << 2;
            if (rem_a >= cand_a) begin
                r_rema <= 24'(rem_a - cand_a); r_roota <= {r_roota[22:0], 1'b1};
            end else begin
                r_rema <= 24'(rem_a); r_roota <= {r_roota[22:0], 1'b0};
            end
            if (rem_b >= cand_b) begin
                r_remb <= 24'(rem_b - cand_b); r_rootb <= {r_rootb[22:0], 1'b1};
            end else begin
                r_remb <= 24'(rem_b); r_rootb <= {r_rootb[22:0], 1'b0};
            end
        end
        if (i_cmd.mag_mul) r_den <= r_roota * r_rootb;
        if (i_cmd.div_start) begin
            r_neg  <= r_dot[AccW-1];
            r_num  <= {1'b0, (r_dot[AccW-1] ? AccW'(-r_dot) : AccW'(r_dot)), 15'd0};
            r_drem <= '0; r_q <= '0; r_qover <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            if (d_sh >= {1'b0, r_den}) begin
                r_drem <= 48'(d_sh - {1'b0, r_den});
                if (r_q[15]) r_qover <= 1'b1;
                r_q <= {r_q[14:0], 1'b1};
            end else begin
                r_drem <= d_sh[47:0];
                if (r_q[15]) r_qover <= 1'b1;
                r_q <= {r_q[14:0], 1'b0};
            end
        end
    end

    // result formation
    logic zero;
    logic [15:0] qs;
    logic ov;
    always_comb begin
        zero = (r_roota == '0) || (r_rootb == '0);
        ov = r_qover || r_q[15];
        qs = ov ? 16'd32767 : r_q;
        o_result.zero_magnitude = zero;
        if (zero) begin
            o_result.similarity = '0;
            o_result.saturated  = r_clamp;
        end else begin
            o_result.similarity = r_neg ? -$signed(qs) : $signed(qs);
            o_result.saturated  = r_clamp || ov;
        end
    end
endmodule

/* rtl/core/csu_ctrl.sv */
// ----------------------------------------------------------------------------
// csu_ctrl
// sequencer for accumulate, root, magnitude product and divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module csu_ctrl import csu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_last,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0, S_M1 = 3'd1, S_M2 = 3'd2, S_M3 = 3'd3,
                           S_SQ = 3'd4, S_MM = 3'd5, S_DIV = 3'd6, S_OUT = 3'd7;
    logic [2:0] r_st, n_st;
    logic [6:0] r_cnt, n_cnt;
    logic r_last, n_last;

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = (r_st == S_OUT);

    // next state and commands
    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_last = r_last;
        o_cmd = '0;
        unique case (r_st)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1; n_last = i_last; n_st = S_M1;
            end
            S_M1: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MulDot; n_st = S_M2;
            end
            S_M2: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MulA; o_cmd.acc_en = 1'b1;
                n_st = S_M3;
            end
            S_M3: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MulB; o_cmd.acc_en = 1'b1;
                n_st = S_SQ; n_cnt = '0;
            end
            // last accumulate; for a last pair, root load once the sums are settled, then 24 steps
            S_SQ: begin
                if (r_cnt == 7'd0) begin
                    o_cmd.acc_en = 1'b1;
                    if (!r_last) n_st = S_IDLE;
                    n_cnt = 7'd1;
                end else if (r_cnt == 7'd1) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_cnt = 7'd2;
                end else begin
                    o_cmd.sqrt_step = 1'b1;
                    n_cnt = r_cnt + 7'd1;
                    if (r_cnt == 7'd25) n_st = S_MM;
                end
            end
            S_MM: begin
                o_cmd.mag_mul = 1'b1; n_st = S_DIV; n_cnt = '0;
            end
            S_DIV: begin
                if (r_cnt == 7'd0) o_cmd.div_start = 1'b1;
                else o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd64) n_st = S_OUT;
            end
            S_OUT: if (i_out_ready) begin
                o_cmd.finish = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_last <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_last <= n_last;
        end
    end
endmodule
